// ===== hw/rtl/pptv_pkg.sv =====
`timescale 1ns / 1ps

package pptv_pkg;

    localparam int NUM_W      = 48;
    localparam int DEN_W      = 32;
    localparam int REM_W      = DEN_W + 1;
    localparam int DIV_STAGES = 24;
    localparam int DIV_STEPS  = NUM_W / DIV_STAGES;

    localparam logic [3:0] CFG_LEFT   = 4'd0;
    localparam logic [3:0] CFG_TOP    = 4'd1;
    localparam logic [3:0] CFG_WIDTH  = 4'd2;
    localparam logic [3:0] CFG_HEIGHT = 4'd3;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_PROJECT = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [3:0]         coeff_index;
        logic signed [31:0] coeff_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } in_item_t;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] win_x;
        logic signed [31:0] win_y;
    } out_item_t;

    typedef struct packed {
        logic ok;
        logic neg;
    } div_tag_t;

endpackage

// ===== hw/rtl/pptv_clip.sv =====
`timescale 1ns / 1ps

module pptv_clip (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                accept,
    input  pptv_pkg::in_item_t  item,
    output logic                valid,
    output logic signed [31:0]  clip_x,
    output logic signed [31:0]  clip_y,
    output logic signed [31:0]  clip_w
);

    logic signed [31:0] mat_reg [16];
    logic               v1_reg;
    logic               v2_reg;
    logic               v3_reg;
    logic signed [31:0] x1_reg;
    logic signed [31:0] y1_reg;
    logic signed [31:0] z1_reg;
    logic signed [31:0] c1_reg [12];
    logic signed [63:0] p2_reg [9];
    logic signed [63:0] p2_next [9];
    logic signed [31:0] t2_reg [3];
    logic signed [31:0] s3_reg [3];
    logic signed [31:0] s3_next [3];
    logic signed [49:0] sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                mat_reg[i] <= '0;
            end
        end
        else if (accept && item.cmd == pptv_pkg::CMD_LOAD)
        begin
            mat_reg[item.coeff_index] <= item.coeff_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= accept && item.cmd == pptv_pkg::CMD_PROJECT;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            p2_next[r * 3 + 0] = 64'(c1_reg[r * 4 + 0]) * 64'(x1_reg);
            p2_next[r * 3 + 1] = 64'(c1_reg[r * 4 + 1]) * 64'(y1_reg);
            p2_next[r * 3 + 2] = 64'(c1_reg[r * 4 + 2]) * 64'(z1_reg);
        end
    end

    always_comb
    begin
        sum = '0;
        for (int r = 0; r < 3; r++)
        begin
            sum = 50'(p2_reg[r * 3 + 0] >>> 16) + 50'(p2_reg[r * 3 + 1] >>> 16)
                + 50'(p2_reg[r * 3 + 2] >>> 16) + 50'(t2_reg[r]);
            if (sum > 50'sh7FFF_FFFF)
            begin
                s3_next[r] = 32'sh7FFF_FFFF;
            end
            else if (sum < -50'sh8000_0000)
            begin
                s3_next[r] = 32'sh8000_0000;
            end
            else
            begin
                s3_next[r] = sum[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg <= item.pos_x;
            y1_reg <= item.pos_y;
            z1_reg <= item.pos_z;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    c1_reg[r * 4 + c] <= mat_reg[(r == 2 ? 3 : r) * 4 + c];
                end
                t2_reg[r] <= c1_reg[r * 4 + 3];
                s3_reg[r] <= s3_next[r];
            end
            for (int i = 0; i < 9; i++)
            begin
                p2_reg[i] <= p2_next[i];
            end
        end
    end

    assign valid  = v3_reg;
    assign clip_x = s3_reg[0];
    assign clip_y = s3_reg[1];
    assign clip_w = s3_reg[2];

endmodule

// ===== hw/rtl/pptv_div.sv =====
`timescale 1ns / 1ps

module pptv_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_valid,
    input  logic [pptv_pkg::NUM_W-1:0]        num,
    input  logic [pptv_pkg::DEN_W-1:0]        den,
    input  pptv_pkg::div_tag_t                in_tag,
    output logic                              out_valid,
    output logic [pptv_pkg::NUM_W-1:0]        quo,
    output pptv_pkg::div_tag_t                out_tag
);

    localparam int S = pptv_pkg::DIV_STAGES;

    logic [pptv_pkg::REM_W-1:0] rem_reg [S];
    logic [pptv_pkg::NUM_W-1:0] num_reg [S];
    logic [pptv_pkg::NUM_W-1:0] quo_reg [S];
    logic [pptv_pkg::DEN_W-1:0] den_reg [S];
    pptv_pkg::div_tag_t         tag_reg [S];
    logic                       vld_reg [S];
    logic [pptv_pkg::REM_W-1:0] rem_next [S];
    logic [pptv_pkg::NUM_W-1:0] num_next [S];
    logic [pptv_pkg::NUM_W-1:0] quo_next [S];

    always_comb
    begin
        logic [pptv_pkg::REM_W-1:0] r;
        logic [pptv_pkg::NUM_W-1:0] n;
        logic [pptv_pkg::NUM_W-1:0] q;
        logic [pptv_pkg::DEN_W-1:0] d;
        for (int s = 0; s < S; s++)
        begin
            if (s == 0)
            begin
                r = '0;
                n = num;
                q = '0;
                d = den;
            end
            else
            begin
                r = rem_reg[s - 1];
                n = num_reg[s - 1];
                q = quo_reg[s - 1];
                d = den_reg[s - 1];
            end
            for (int k = 0; k < pptv_pkg::DIV_STEPS; k++)
            begin
                r = {r[pptv_pkg::REM_W-2:0], n[pptv_pkg::NUM_W-1]};
                n = {n[pptv_pkg::NUM_W-2:0], 1'b0};
                if (r >= {1'b0, d})
                begin
                    r = r - {1'b0, d};
                    q = {q[pptv_pkg::NUM_W-2:0], 1'b1};
                end
                else
                begin
                    q = {q[pptv_pkg::NUM_W-2:0], 1'b0};
                end
            end
            rem_next[s] = r;
            num_next[s] = n;
            quo_next[s] = q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < S; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < S; s++)
            begin
                vld_reg[s] <= vld_reg[s - 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < S; s++)
            begin
                rem_reg[s] <= rem_next[s];
                num_reg[s] <= num_next[s];
                quo_reg[s] <= quo_next[s];
                den_reg[s] <= (s == 0) ? den : den_reg[s == 0 ? 0 : s - 1];
                tag_reg[s] <= (s == 0) ? in_tag : tag_reg[s == 0 ? 0 : s - 1];
            end
        end
    end

    assign out_valid = vld_reg[S - 1];
    assign quo       = quo_reg[S - 1];
    assign out_tag   = tag_reg[S - 1];

endmodule

// ===== hw/rtl/pptv_vp.sv =====
`timescale 1ns / 1ps

module pptv_vp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic [pptv_pkg::NUM_W-1:0]  quo_x,
    input  logic [pptv_pkg::NUM_W-1:0]  quo_y,
    input  pptv_pkg::div_tag_t          tag_x,
    input  pptv_pkg::div_tag_t          tag_y,
    input  logic signed [15:0]          vp_left,
    input  logic signed [15:0]          vp_top,
    input  logic [15:0]                 vp_width,
    input  logic [15:0]                 vp_height,
    output logic                        out_valid,
    output pptv_pkg::out_item_t         out_item
);

    logic                v1_reg;
    logic                v2_reg;
    logic                v3_reg;
    logic                ok1_reg;
    logic                ok2_reg;
    logic signed [31:0]  nx1_reg;
    logic signed [31:0]  ny1_reg;
    logic signed [49:0]  px2_reg;
    logic signed [49:0]  py2_reg;
    pptv_pkg::out_item_t out_reg;
    pptv_pkg::out_item_t out_next;

    function automatic logic signed [31:0] sat_quo(input logic [47:0] q, input logic neg);
        logic [48:0] m;
        m = 49'd0 - {1'b0, q};
        if (neg)
        begin
            sat_quo = (q > 48'h8000_0000) ? 32'sh8000_0000 : m[31:0];
        end
        else
        begin
            sat_quo = (q > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
        end
    endfunction

    function automatic logic signed [31:0] finish(input logic signed [49:0] p,
                                                  input logic signed [15:0] org);
        logic signed [49:0] h;
        logic signed [50:0] w;
        h = (p < 50'sd0) ? ((p + 50'sd1) >>> 1) : (p >>> 1);
        w = 51'(h) + (51'(org) <<< 16);
        if (w > 51'sh7FFF_FFFF)
        begin
            finish = 32'sh7FFF_FFFF;
        end
        else if (w < -51'sh8000_0000)
        begin
            finish = 32'sh8000_0000;
        end
        else
        begin
            finish = w[31:0];
        end
    endfunction

    always_comb
    begin
        out_next.ok    = ok2_reg;
        out_next.win_x = ok2_reg ? finish(px2_reg, vp_left) : '0;
        out_next.win_y = ok2_reg ? finish(py2_reg, vp_top) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok1_reg <= tag_x.ok;
            nx1_reg <= sat_quo(quo_x, tag_x.neg);
            ny1_reg <= sat_quo(quo_y, tag_y.neg);
            ok2_reg <= ok1_reg;
            px2_reg <= (50'(nx1_reg) + 50'sd65536) * $signed({34'd0, vp_width});
            py2_reg <= (50'sd65536 - 50'(ny1_reg)) * $signed({34'd0, vp_height});
            out_reg <= out_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = out_reg;

endmodule

// ===== hw/rtl/project_point_to_viewport.sv =====
`timescale 1ns / 1ps

// Projects points through a stored 4x4 matrix into viewport coordinates, all in signed
// Q16.16. A load request writes one matrix coefficient and gives no result; a project
// request gives one. One request is taken every cycle unless stalled; the rate is set
// by the fully pipelined datapath, whose length comes mostly from the two 24-stage
// dividers that retire two quotient bits per stage. A stall on a valid output holds the
// whole pipeline. Viewport registers are written through the configuration port.

module project_point_to_viewport (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  pptv_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output pptv_pkg::out_item_t  out_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [3:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    logic                       adv;
    logic                       accept;
    logic signed [15:0]         left_reg;
    logic signed [15:0]         top_reg;
    logic [15:0]                width_reg;
    logic [15:0]                height_reg;
    logic                       clip_valid;
    logic signed [31:0]         clip_x;
    logic signed [31:0]         clip_y;
    logic signed [31:0]         clip_w;
    logic [31:0]                abs_x;
    logic [31:0]                abs_y;
    logic [31:0]                abs_w;
    pptv_pkg::div_tag_t         tag_x_in;
    pptv_pkg::div_tag_t         tag_y_in;
    pptv_pkg::div_tag_t         tag_x_out;
    pptv_pkg::div_tag_t         tag_y_out;
    logic                       divx_valid;
    logic                       divy_valid;
    logic [pptv_pkg::NUM_W-1:0] quo_x;
    logic [pptv_pkg::NUM_W-1:0] quo_y;

    assign adv       = !out_valid || !out_stall;
    assign in_stall  = !adv;
    assign accept    = in_valid && adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            width_reg  <= 16'd640;
            height_reg <= 16'd480;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pptv_pkg::CFG_LEFT:   left_reg   <= cfg_data;
                pptv_pkg::CFG_TOP:    top_reg    <= cfg_data;
                pptv_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                pptv_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    pptv_clip u_clip (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .accept (accept),
        .item   (in_item),
        .valid  (clip_valid),
        .clip_x (clip_x),
        .clip_y (clip_y),
        .clip_w (clip_w)
    );

    assign abs_x = clip_x[31] ? 32'd0 - clip_x : clip_x;
    assign abs_y = clip_y[31] ? 32'd0 - clip_y : clip_y;
    assign abs_w = clip_w[31] ? 32'd0 - clip_w : clip_w;

    assign tag_x_in.ok  = clip_w != 32'sd0;
    assign tag_x_in.neg = clip_x[31] ^ clip_w[31];
    assign tag_y_in.ok  = clip_w != 32'sd0;
    assign tag_y_in.neg = clip_y[31] ^ clip_w[31];

    pptv_div u_divx (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (clip_valid),
        .num       ({abs_x, 16'd0}),
        .den       (abs_w),
        .in_tag    (tag_x_in),
        .out_valid (divx_valid),
        .quo       (quo_x),
        .out_tag   (tag_x_out)
    );

    pptv_div u_divy (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (clip_valid),
        .num       ({abs_y, 16'd0}),
        .den       (abs_w),
        .in_tag    (tag_y_in),
        .out_valid (divy_valid),
        .quo       (quo_y),
        .out_tag   (tag_y_out)
    );

    pptv_vp u_vp (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (divx_valid),
        .quo_x     (quo_x),
        .quo_y     (quo_y),
        .tag_x     (tag_x_out),
        .tag_y     (tag_y_out),
        .vp_left   (left_reg),
        .vp_top    (top_reg),
        .vp_width  (width_reg),
        .vp_height (height_reg),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        divx_valid == divy_valid)
        else $error("divider valids diverged");

    a_not_ok_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.ok |-> out_item.win_x == 32'sd0 && out_item.win_y == 32'sd0)
        else $error("result without w carries nonzero coordinates");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a blocked result");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import pptv_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_item = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    project_point_to_viewport uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    logic signed [31:0] matrix [16];
    logic signed [15:0] vp_left;
    logic signed [15:0] vp_top;
    logic [15:0]        vp_width;
    logic [15:0]        vp_height;

    in_item_t  pending_requests [$];
    out_item_t expected_points [$];
    int        errors = 0;
    bit        send_idle_en = 1'b1;
    bit        recv_idle_en = 1'b1;
    int        hold_cycles = 0;
    bit        sender_paused = 1'b0;
    bit        in_taken = 1'b0;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint floor_q16(longint v);
        return v >>> 16;
    endfunction

    function automatic longint clip_component(int row, longint x, longint y, longint z);
        longint acc;
        acc = floor_q16(longint'(matrix[row*4]) * x) + floor_q16(longint'(matrix[row*4+1]) * y)
            + floor_q16(longint'(matrix[row*4+2]) * z) + longint'(matrix[row*4+3]);
        return sat32(acc);
    endfunction

    task automatic project_request(input in_item_t req);
        longint x, y, z, cx, cy, cw, nx, ny, wx, wy;
        out_item_t res;
        if (req.cmd == CMD_LOAD) begin
            matrix[req.coeff_index] = req.coeff_value;
            return;
        end
        x = req.pos_x;
        y = req.pos_y;
        z = req.pos_z;
        cx = clip_component(0, x, y, z);
        cy = clip_component(1, x, y, z);
        cw = clip_component(3, x, y, z);
        res = '0;
        if (cw != 0) begin
            nx = sat32((cx * 65536) / cw);
            ny = sat32((cy * 65536) / cw);
            wx = ((nx + 65536) * longint'(vp_width)) / 2 + longint'(vp_left) * 65536;
            wy = ((65536 - ny) * longint'(vp_height)) / 2 + longint'(vp_top) * 65536;
            res.ok = 1'b1;
            res.win_x = 32'(sat32(wx));
            res.win_y = 32'(sat32(wy));
        end
        expected_points.push_back(res);
    endtask

    always @(posedge clk) begin
        in_taken = in_valid && !in_stall;
        if (in_valid && !in_stall) begin
            project_request(in_item);
        end
        if (out_valid && !out_stall) begin
            if (expected_points.size() == 0) begin
                $display("%0t: unexpected result %p", $time, out_item);
                errors++;
            end
            else begin
                if (out_item !== expected_points[0]) begin
                    $display("%0t: mismatch expected %p actual %p", $time,
                             expected_points[0], out_item);
                    errors++;
                end
                void'(expected_points.pop_front());
            end
        end
    end

    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_valid || in_taken) begin
                if (!sender_paused && pending_requests.size() > 0
                    && !(send_idle_en && $urandom_range(99) < 38)) begin
                    in_item <= pending_requests.pop_front();
                    in_valid <= 1'b1;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                out_stall <= 1'b1;
            end
            else begin
                out_stall <= recv_idle_en && ($urandom_range(99) < 38);
            end
        end
    end

    task automatic write_reg(input logic [3:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_LEFT:   vp_left = val;
            CFG_TOP:    vp_top = val;
            CFG_WIDTH:  vp_width = val;
            CFG_HEIGHT: vp_height = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_requests.size() > 0 || in_valid || expected_points.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic in_item_t load_req(int idx, logic [31:0] val);
        in_item_t r;
        r = '0;
        r.cmd = CMD_LOAD;
        r.coeff_index = 4'(idx);
        r.coeff_value = val;
        r.pos_x = $urandom();
        r.pos_y = $urandom();
        r.pos_z = $urandom();
        return r;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(65536 * 8) - 65536 * 4;
            2: return 32'(int'($urandom_range(20)) - 10) <<< 16;
            default: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
        endcase
    endfunction

    function automatic in_item_t point_req(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        in_item_t r;
        r.cmd = CMD_PROJECT;
        r.coeff_index = 4'($urandom());
        r.coeff_value = $urandom();
        r.pos_x = x;
        r.pos_y = y;
        r.pos_z = z;
        return r;
    endfunction

    task automatic queue_matrix(input bit perspective);
        for (int i = 0; i < 16; i++) begin
            logic [31:0] v;
            if (perspective && $urandom_range(3) != 0)
                v = (i % 5 == 0) ? 32'h0001_0000 : ((i == 14) ? 32'hFFFF_0000 : 32'h0);
            else
                v = rand_coord();
            if (perspective && i == 15) v = 32'h0;
            pending_requests.push_back(load_req(i, v));
        end
    endtask

    initial begin
        for (int i = 0; i < 16; i++) matrix[i] = '0;
        vp_left = 16'sd0;
        vp_top = 16'sd0;
        vp_width = 16'd640;
        vp_height = 16'd480;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        pending_requests.push_back(point_req(32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
        pending_requests.push_back(load_req(15, 32'h0001_0000));
        pending_requests.push_back(load_req(0, 32'h7FFF_FFFF));
        pending_requests.push_back(load_req(5, 32'h8000_0000));
        pending_requests.push_back(load_req(3, 32'h8000_0000));
        pending_requests.push_back(point_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_requests.push_back(point_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        pending_requests.push_back(point_req(32'h0, 32'hFFFF_FFFF, 32'h1));
        pending_requests.push_back(load_req(15, 32'h0000_0001));
        pending_requests.push_back(point_req(32'h0001_0000, 32'hFFFF_0000, 32'h0));
        pending_requests.push_back(load_req(15, 32'hFFFF_FFFF));
        pending_requests.push_back(point_req(32'h0002_0000, 32'h0003_0000, 32'h0));
        pending_requests.push_back(load_req(12, 32'h0001_0000));
        pending_requests.push_back(load_req(15, 32'h0));
        pending_requests.push_back(point_req(32'h0, 32'h1234_5678, 32'h0));
        pending_requests.push_back(point_req(32'hFFFF_FFFF, 32'h0, 32'h0));
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin write_reg(CFG_LEFT, 16'h7FFF); write_reg(CFG_TOP, 16'h8000);
                         write_reg(CFG_WIDTH, 16'hFFFF); write_reg(CFG_HEIGHT, 16'h0); end
                1: begin write_reg(CFG_LEFT, 16'h8000); write_reg(CFG_TOP, 16'h7FFF);
                         write_reg(CFG_WIDTH, 16'h0); write_reg(CFG_HEIGHT, 16'hFFFF); end
                2: begin write_reg(CFG_LEFT, 16'd0); write_reg(CFG_TOP, 16'd0);
                         write_reg(CFG_WIDTH, 16'd1920); write_reg(CFG_HEIGHT, 16'd1080); end
                default: begin write_reg(CFG_LEFT, 16'($urandom()));
                         write_reg(CFG_TOP, 16'($urandom()));
                         write_reg(CFG_WIDTH, 16'($urandom()));
                         write_reg(CFG_HEIGHT, 16'($urandom())); end
            endcase
            send_idle_en = (phase != 3);
            recv_idle_en = (phase != 3);
            queue_matrix(phase % 3 != 1);
            for (int n = 0; n < 55; n++) begin
                if ($urandom_range(9) == 0)
                    pending_requests.push_back(load_req($urandom_range(15), rand_coord()));
                else
                    pending_requests.push_back(point_req(rand_coord(), rand_coord(),
                                                         rand_coord()));
            end
            if (phase == 2) begin
                hold_cycles = 150;
                wait (pending_requests.size() < 20);
                sender_paused = 1'b1;
                wait (expected_points.size() == 0 && hold_cycles == 0);
                @(posedge clk);
                wait (expected_points.size() == 0);
                sender_paused = 1'b0;
            end
            drain();
        end

        drain();
        if (errors == 0)
            $display("project_point_to_viewport verification clean");
        else
            $display("project_point_to_viewport verification failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("project_point_to_viewport verification failed");
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/pptv_pkg.sv
hw/rtl/pptv_clip.sv
hw/rtl/pptv_div.sv
hw/rtl/pptv_vp.sv
hw/rtl/project_point_to_viewport.sv
sim/testbench.sv
